[src/node_store_integrate_nearest_defines.svh]
`ifndef NODE_STORE_INTEGRATE_NEAREST_DEFINES_SVH
`define NODE_STORE_INTEGRATE_NEAREST_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define NSI_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define NSI_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/nsi_pkg.sv]
package nsi_pkg;

    localparam int MAX_NODES = 1024;
    localparam int ADDR_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int COORD_W   = 24;
    localparam int RADIUS_W  = 23;
    localparam int ITER_W    = 8;
    localparam int DIST_W    = 52;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int BEST_W    = 2 * RADIUS_W;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_ADVANCE = 2'd1,
        REQ_QUERY   = 2'd2,
        REQ_NONE    = 2'd3
    } req_code_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADV_SCAN,
        ST_ADV_WAIT,
        ST_QRY_SCAN,
        ST_QRY_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic [ADDR_W-1:0]          node_index;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic signed [COORD_W-1:0]  pos_z;
        logic signed [COORD_W-1:0]  vel_x;
        logic signed [COORD_W-1:0]  vel_y;
        logic signed [COORD_W-1:0]  vel_z;
        logic                       pinned;
        logic [ITER_W-1:0]          iterations;
        logic [RADIUS_W-1:0]        max_radius;
    } req_t;

    typedef struct packed {
        logic                       found;
        logic [ADDR_W-1:0]          best_index;
        logic [DIST_W-1:0]          best_dist_sq;
    } rsp_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } pos_word_t;

    typedef struct packed {
        logic                       fixed;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } vel_word_t;

endpackage

[src/node_store_integrate_nearest.sv]
// channel   direction  handshake               payload
// req       in         req_valid / req_ready   req (req_t)
// rsp       out        rsp_valid / rsp_ready   rsp (rsp_t)
// cfg       in         cfg_we                  cfg_wdata (node_count)
//
// after reset a clearing pass zeroes all MAX_NODES entries while req_ready is low
// write or unused code goes straight to ST_DONE; query: one entry read per cycle, then a drain
// advance: iterations passes over the n entries; a wait state after each pass lets the last
//   write-back land before the next pass begins reading
// n is node_count limited to MAX_NODES; the read address shared by both memories sets the pace
// a new transaction is taken while the previous result waits in the output register

`include "node_store_integrate_nearest_defines.svh"

module node_store_integrate_nearest
    import nsi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] s;
        logic signed [COORD_W-1:0] r;
        begin
            s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
            if (s[COORD_W] != s[COORD_W-1])
            begin
                r = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
            end
            else
            begin
                r = s[COORD_W-1:0];
            end
            return r;
        end
    endfunction

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        logic [COORD_W:0] m;
        begin
            d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
            m = d[COORD_W] ? (COORD_W+1)'(-d) : d;
            return m[COORD_W-1:0];
        end
    endfunction

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   node_count_reg;
    logic [CNT_W-1:0]   n_eff;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic               scan_last;
    logic               req_fire;

    logic               rd_en;
    logic               clear_en;
    logic               load_rsp;
    logic               adv_wb;

    pos_word_t          pos_mem [MAX_NODES];
    vel_word_t          vel_mem [MAX_NODES];
    pos_word_t          pos_rdata_reg;
    vel_word_t          vel_rdata_reg;
    logic               pos_we;
    logic [ADDR_W-1:0]  pos_waddr;
    pos_word_t          pos_wdata;
    logic               vel_we;
    logic [ADDR_W-1:0]  vel_waddr;
    vel_word_t          vel_wdata;
    logic [ADDR_W-1:0]  rd_addr;

    logic               p1_valid_reg;
    logic [ADDR_W-1:0]  p1_idx_reg;
    logic               p2_valid_reg;
    logic [ADDR_W-1:0]  p2_idx_reg;
    logic [COORD_W-1:0] mag_x_reg, mag_y_reg, mag_z_reg;
    logic               p3_valid_reg;
    logic [ADDR_W-1:0]  p3_idx_reg;
    logic [SQ_W-1:0]    sq_x_reg, sq_y_reg, sq_z_reg;
    logic [SUM_W-1:0]   dist_sum;
    logic               closer;

    pos_word_t          qpt_reg;
    logic [BEST_W-1:0]  best_reg;
    logic [ADDR_W-1:0]  best_idx_reg;
    logic               found_reg;

    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    assign n_eff     = (node_count_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_reg;
    assign scan_last = (cnt_reg == n_reg - CNT_W'(1));
    assign req_fire  = req_valid && req_ready;
    assign rd_addr   = cnt_reg[ADDR_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == CNT_W'(MAX_NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    priority if (req.req_type == REQ_ADVANCE && req.iterations != '0
                                 && n_eff != '0)
                    begin
                        state_next = ST_ADV_SCAN;
                    end
                    else if (req.req_type == REQ_QUERY && n_eff != '0)
                    begin
                        state_next = ST_QRY_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ADV_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_ADV_WAIT;
                end
            end
            ST_ADV_WAIT:
            begin
                state_next = (iter_reg == ITER_W'(1)) ? ST_DONE : ST_ADV_SCAN;
            end
            ST_QRY_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_QRY_DRAIN;
                end
            end
            ST_QRY_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg && !p3_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req_ready = 1'b0;
        rd_en     = 1'b0;
        clear_en  = 1'b0;
        load_rsp  = 1'b0;
        adv_wb    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:     clear_en  = 1'b1;
            ST_IDLE:      req_ready = 1'b1;
            ST_ADV_SCAN:
            begin
                rd_en  = 1'b1;
                adv_wb = p1_valid_reg && !vel_rdata_reg.fixed;
            end
            ST_ADV_WAIT:  adv_wb = p1_valid_reg && !vel_rdata_reg.fixed;
            ST_QRY_SCAN:  rd_en  = 1'b1;
            ST_QRY_DRAIN: rd_en  = 1'b0;
            ST_DONE:      load_rsp = !rsp_valid_reg || rsp_ready;
            default:      clear_en = 1'b0;
        endcase
    end

    // memory write selection
    always_comb
    begin
        pos_we    = 1'b0;
        pos_waddr = p1_idx_reg;
        pos_wdata = '{x: sat_add(pos_rdata_reg.x, vel_rdata_reg.x),
                      y: sat_add(pos_rdata_reg.y, vel_rdata_reg.y),
                      z: sat_add(pos_rdata_reg.z, vel_rdata_reg.z)};
        vel_we    = 1'b0;
        vel_waddr = req.node_index;
        vel_wdata = '{fixed: req.pinned, x: req.vel_x, y: req.vel_y, z: req.vel_z};
        priority if (clear_en)
        begin
            pos_we    = 1'b1;
            pos_waddr = cnt_reg[ADDR_W-1:0];
            pos_wdata = '0;
            vel_we    = 1'b1;
            vel_waddr = cnt_reg[ADDR_W-1:0];
            vel_wdata = '0;
        end
        else if (req_fire && req.req_type == REQ_WRITE)
        begin
            pos_we    = 1'b1;
            pos_waddr = req.node_index;
            pos_wdata = '{x: req.pos_x, y: req.pos_y, z: req.pos_z};
            vel_we    = 1'b1;
        end
        else if (adv_wb)
        begin
            pos_we    = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (rd_en)
        begin
            pos_rdata_reg <= pos_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vel_we)
        begin
            vel_mem[vel_waddr] <= vel_wdata;
        end
        if (rd_en)
        begin
            vel_rdata_reg <= vel_mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            node_count_reg <= '0;
            cnt_reg        <= '0;
            iter_reg       <= '0;
            n_reg          <= '0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            p3_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= rd_en;
            p2_valid_reg <= p1_valid_reg
                            && (state_reg == ST_QRY_SCAN || state_reg == ST_QRY_DRAIN);
            p3_valid_reg <= p2_valid_reg;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            unique case (state_reg)
                ST_CLEAR, ST_ADV_SCAN, ST_QRY_SCAN: cnt_reg <= cnt_reg + CNT_W'(1);
                ST_ADV_WAIT:
                begin
                    cnt_reg  <= '0;
                    iter_reg <= iter_reg - ITER_W'(1);
                end
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        cnt_reg  <= '0;
                        iter_reg <= req.iterations;
                        n_reg    <= n_eff;
                    end
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
            if (req_fire)
            begin
                found_reg <= 1'b0;
            end
            else if (p3_valid_reg && closer)
            begin
                found_reg <= 1'b1;
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign dist_sum = SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg) + SUM_W'(sq_z_reg);
    assign closer   = dist_sum < SUM_W'(best_reg);

    // query pipeline and best candidate
    always_ff @(posedge clk)
    begin
        p1_idx_reg <= rd_addr;
        p2_idx_reg <= p1_idx_reg;
        mag_x_reg  <= abs_diff(pos_rdata_reg.x, qpt_reg.x);
        mag_y_reg  <= abs_diff(pos_rdata_reg.y, qpt_reg.y);
        mag_z_reg  <= abs_diff(pos_rdata_reg.z, qpt_reg.z);
        p3_idx_reg <= p2_idx_reg;
        sq_x_reg   <= SQ_W'(mag_x_reg) * SQ_W'(mag_x_reg);
        sq_y_reg   <= SQ_W'(mag_y_reg) * SQ_W'(mag_y_reg);
        sq_z_reg   <= SQ_W'(mag_z_reg) * SQ_W'(mag_z_reg);
        if (req_fire)
        begin
            qpt_reg      <= '{x: req.pos_x, y: req.pos_y, z: req.pos_z};
            best_reg     <= BEST_W'(req.max_radius) * BEST_W'(req.max_radius);
            best_idx_reg <= '0;
        end
        else if (p3_valid_reg && closer)
        begin
            best_reg     <= dist_sum[BEST_W-1:0];
            best_idx_reg <= p3_idx_reg;
        end
        if (load_rsp)
        begin
            rsp_reg.found        <= found_reg;
            rsp_reg.best_index   <= best_idx_reg;
            rsp_reg.best_dist_sq <= found_reg ? DIST_W'(best_reg) : '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `NSI_ASSERT_NOW(a_no_rw_collision, pos_we && rd_en, pos_waddr != rd_addr,
        "write-back and read hit the same entry")
    `NSI_ASSERT_NOW(a_query_no_write,
        state_reg == ST_QRY_SCAN || state_reg == ST_QRY_DRAIN, !pos_we,
        "position written during a query scan")
    `NSI_ASSERT_NOW(a_empty_result_zero, rsp_valid && !rsp.found,
        rsp.best_index == '0 && rsp.best_dist_sq == '0,
        "result without a hit carries index or distance")
    `NSI_ASSERT_NEXT(a_done_to_idle, load_rsp, state_reg == ST_IDLE && rsp_valid,
        "result load did not return to idle with a valid transaction")

endmodule
